[src/emag_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// emag_pkg
// Shared constants, types and helpers for the 3x3 edge magnitude block.
// ----------------------------------------------------------------------------
package emag_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int DIM_W       = 11;
    localparam int EDGE_W      = 10;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int SUM_W       = 12;
    localparam int LB_AW       = $clog2(MAX_WIDTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_SOBEL     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PREWITT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LAPLACIAN = 2'd2;

    localparam logic [DIM_W-1:0] DIM_MIN       = 11'd3;
    localparam logic [DIM_W-1:0] WIDTH_LIMIT   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT  = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RESET_WIDTH   = 11'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT  = 11'd480;

    localparam logic [PIX_W-1:0] GRAD_CLAMP = 8'd255;

    typedef logic [PIX_W-1:0] pix_t;

    // geometry already clamped to the legal range
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [MODE_W-1:0] mode;
    } emag_cfg_t;

    // one window ready for the arithmetic, index row*3+col, row 0 on top
    typedef struct packed {
        pix_t [8:0]         win;
        logic               border;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } emag_item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN) r = DIM_MIN;
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

[src/emag_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// emag_front
// Raster position, line buffers and 3x3 window; sorts each pixel into
// border / interior / no-result and hands emitting windows to the queue.
// ----------------------------------------------------------------------------
module emag_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  emag_pkg::emag_cfg_t               cfg,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  emag_pkg::pix_t                    pixel,
    input  logic                              start_of_frame,
    input  logic [emag_pkg::QCNT_W-1:0]       q_level,
    output logic                              push,
    output emag_pkg::emag_item_t              push_item
);
    import emag_pkg::*;

    logic               accept;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] r_cur, c_cur;
    logic [DIM_W-1:0]   r_inc, c_inc;
    logic               emit, border, last;

    // A stage: the cycle after accept, line buffer data is back
    logic               a_valid_reg;
    logic               a_emit_reg;
    logic               a_hit_reg;
    logic               a_border_reg;
    logic               a_last_reg;
    logic [COORD_W-1:0] a_row_reg, a_col_reg;
    logic [LB_AW-1:0]   a_addr_reg;
    pix_t               a_px_reg;
    logic [2*PIX_W-1:0] lb_rd_reg;
    logic [2*PIX_W-1:0] fwd_reg;
    pix_t               a_mid, a_top;

    // entry = {row r-1, row r-2} at one column
    logic [2*PIX_W-1:0] lb_mem [MAX_WIDTH];

    pix_t [8:0] window_reg;
    pix_t [8:0] window_next;

    assign pix_ready = ((QCNT_W+1)'(q_level) + (QCNT_W+1)'(a_valid_reg))
                       < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept    = pix_valid && pix_ready;

    assign r_cur = start_of_frame ? '0 : row_reg;
    assign c_cur = start_of_frame ? '0 : col_reg;
    assign r_inc = {1'b0, r_cur} + 1'b1;
    assign c_inc = {1'b0, c_cur} + 1'b1;

    always_comb
    begin
        if (c_inc >= cfg.width)
        begin
            col_next = '0;
            row_next = (r_inc >= cfg.height) ? '0 : r_inc[COORD_W-1:0];
        end
        else
        begin
            col_next = c_inc[COORD_W-1:0];
            row_next = r_cur;
        end
    end

    // result is for (r-1, c-1); border test folded onto r and c
    assign emit   = (r_cur != '0) && (c_cur != '0);
    assign border = (r_cur == COORD_W'(1)) || (c_cur == COORD_W'(1))
                    || ({1'b0, r_cur} >= cfg.height) || ({1'b0, c_cur} >= cfg.width);
    assign last   = ({1'b0, r_cur} == cfg.height - 1'b1)
                    && ({1'b0, c_cur} == cfg.width - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_emit_reg  <= 1'b0;
            a_hit_reg   <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            // previous word writes this column at the same edge
            a_hit_reg   <= accept && a_valid_reg && (a_addr_reg == c_cur[LB_AW-1:0]);
            if (accept)
            begin
                row_reg    <= row_next;
                col_reg    <= col_next;
                a_emit_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_border_reg <= border;
            a_last_reg   <= last;
            a_row_reg    <= r_cur - 1'b1;
            a_col_reg    <= c_cur - 1'b1;
            a_addr_reg   <= c_cur[LB_AW-1:0];
            a_px_reg     <= pixel;
            fwd_reg      <= {a_px_reg, a_mid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
            lb_mem[a_addr_reg] <= {a_px_reg, a_mid};
        if (accept)
            lb_rd_reg <= lb_mem[c_cur[LB_AW-1:0]];
    end

    assign a_mid = a_hit_reg ? fwd_reg[2*PIX_W-1:PIX_W] : lb_rd_reg[2*PIX_W-1:PIX_W];
    assign a_top = a_hit_reg ? fwd_reg[PIX_W-1:0]       : lb_rd_reg[PIX_W-1:0];

    always_comb
    begin
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = a_top;
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = a_mid;
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = a_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (a_valid_reg)
            window_reg <= window_next;
    end

    assign push             = a_valid_reg && a_emit_reg;
    assign push_item.win    = window_next;
    assign push_item.border = a_border_reg;
    assign push_item.row    = a_row_reg;
    assign push_item.col    = a_col_reg;
    assign push_item.last   = a_last_reg;

    a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> a_valid_reg)
        else $error("accepted word did not reach A stage");

    no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_level < QCNT_W'(QUEUE_DEPTH)))
        else $error("push into full queue");

    fwd_only_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
        a_hit_reg |-> a_valid_reg)
        else $error("line buffer forward without a word in A stage");

endmodule
`default_nettype wire

[src/emag_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// emag_queue
// Short FIFO of windows between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module emag_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  emag_pkg::emag_item_t          push_item,
    input  logic                          pop,
    output logic                          q_valid,
    output emag_pkg::emag_item_t          head_item,
    output logic [emag_pkg::QCNT_W-1:0]   level
);
    import emag_pkg::*;

    emag_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign q_valid   = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];
    assign level     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue level out of range");

    empty_ptrs_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty but pointers differ");

endmodule
`default_nettype wire

[src/emag_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// emag_back
// Kernel arithmetic in two stages: gradients / Laplacian sum, then
// magnitude, clamp and the result register.
// ----------------------------------------------------------------------------
module emag_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [emag_pkg::MODE_W-1:0]      mode,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  emag_pkg::emag_item_t             q_item,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic                             out_valid,
    output logic [emag_pkg::COORD_W-1:0]     out_row,
    output logic [emag_pkg::COORD_W-1:0]     out_col,
    output logic [emag_pkg::EDGE_W-1:0]      edge_value,
    output logic                             frame_done
);
    import emag_pkg::*;

    logic signed [SUM_W-1:0] p [9];
    logic signed [SUM_W-1:0] k3, k5, k1, k7;
    logic signed [SUM_W-1:0] gx, gy, lap;
    logic                    sobel, lap_mode;
    logic                    s1_ready, s2_ready;

    logic                    s1_valid_reg;
    logic signed [SUM_W-1:0] s1_gx_reg, s1_gy_reg, s1_lap_reg;
    logic                    s1_lap_mode_reg, s1_border_reg, s1_last_reg;
    logic [COORD_W-1:0]      s1_row_reg, s1_col_reg;

    logic signed [SUM_W-1:0] gx_abs, gy_abs, mag;
    logic [EDGE_W-1:0]       grad_val, lap_val, edge_calc;

    logic                    res_valid_reg;
    logic [COORD_W-1:0]      res_row_reg, res_col_reg;
    logic [EDGE_W-1:0]       res_edge_reg;
    logic                    res_last_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            p[i] = SUM_W'(q_item.win[i]);
    end

    assign sobel    = (mode == MODE_SOBEL);
    assign lap_mode = (mode != MODE_SOBEL) && (mode != MODE_PREWITT);

    // centre-column/row weight is 2 for Sobel, 1 for Prewitt
    assign k1 = sobel ? (p[1] <<< 1) : p[1];
    assign k3 = sobel ? (p[3] <<< 1) : p[3];
    assign k5 = sobel ? (p[5] <<< 1) : p[5];
    assign k7 = sobel ? (p[7] <<< 1) : p[7];

    assign gx  = (p[2] + k5 + p[8]) - (p[0] + k3 + p[6]);
    assign gy  = (p[6] + k7 + p[8]) - (p[0] + k1 + p[2]);
    assign lap = (p[1] + p[3] + p[5] + p[7]) - (p[4] <<< 2);

    assign s2_ready = !res_valid_reg || res_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_pop    = q_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= q_valid;
            if (s2_ready)
                res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_gx_reg       <= gx;
            s1_gy_reg       <= gy;
            s1_lap_reg      <= lap;
            s1_lap_mode_reg <= lap_mode;
            s1_border_reg   <= q_item.border;
            s1_last_reg     <= q_item.last;
            s1_row_reg      <= q_item.row;
            s1_col_reg      <= q_item.col;
        end
    end

    assign gx_abs   = (s1_gx_reg < 0) ? -s1_gx_reg : s1_gx_reg;
    assign gy_abs   = (s1_gy_reg < 0) ? -s1_gy_reg : s1_gy_reg;
    assign mag      = (gx_abs > gy_abs) ? gx_abs : gy_abs;
    assign grad_val = (mag > SUM_W'(GRAD_CLAMP)) ? EDGE_W'(GRAD_CLAMP) : mag[EDGE_W-1:0];
    assign lap_val  = (s1_lap_reg < 0) ? '0 : s1_lap_reg[EDGE_W-1:0];

    always_comb
    begin
        if (s1_border_reg)
            edge_calc = '0;
        else if (s1_lap_mode_reg)
            edge_calc = lap_val;
        else
            edge_calc = grad_val;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            res_row_reg  <= s1_row_reg;
            res_col_reg  <= s1_col_reg;
            res_edge_reg <= edge_calc;
            res_last_reg <= s1_last_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_valid  = res_valid_reg;
    assign out_row    = res_row_reg;
    assign out_col    = res_col_reg;
    assign edge_value = res_edge_reg;
    assign frame_done = res_last_reg;

    s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_row_reg)
                                          && $stable(s1_col_reg)))
        else $error("first stage lost a word while stalled");

    pop_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> s1_valid_reg)
        else $error("popped word did not reach first stage");

endmodule
`default_nettype wire

[src/edge_magnitude_3x3.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// edge_magnitude_3x3
// Path: pixel accept, A stage, window queue, first arithmetic stage, result reg.
// Throughput: one word per clock while res_ready holds; a 4-entry window queue
// lets the front keep taking pixels while the result side stalls, until it fills.
// Reset: 640x480 Sobel, position (0,0), window zero; line buffers not cleared.
// ----------------------------------------------------------------------------
module edge_magnitude_3x3 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [emag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [emag_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  logic [emag_pkg::PIX_W-1:0]        pixel,
    input  logic                              start_of_frame,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic                              out_valid,
    output logic [emag_pkg::COORD_W-1:0]      out_row,
    output logic [emag_pkg::COORD_W-1:0]      out_col,
    output logic [emag_pkg::EDGE_W-1:0]       edge_value,
    output logic                              frame_done
);
    import emag_pkg::*;

    logic [DIM_W-1:0]  frame_width_reg, frame_height_reg;
    logic [MODE_W-1:0] edge_mode_reg;
    emag_cfg_t         cfg;

    logic              push, pop, q_valid;
    emag_item_t        push_item, head_item;
    logic [QCNT_W-1:0] q_level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
            edge_mode_reg    <= MODE_SOBEL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_EDGE_MODE:    edge_mode_reg    <= cfg_data[MODE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.width  = clamp_dim(frame_width_reg, WIDTH_LIMIT);
    assign cfg.height = clamp_dim(frame_height_reg, HEIGHT_LIMIT);
    assign cfg.mode   = edge_mode_reg;

    emag_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .pix_valid      (pix_valid),
        .pix_ready      (pix_ready),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .q_level        (q_level),
        .push           (push),
        .push_item      (push_item)
    );

    emag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .head_item (head_item),
        .level     (q_level)
    );

    emag_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (cfg.mode),
        .q_valid    (q_valid),
        .q_pop      (pop),
        .q_item     (head_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_valid  (out_valid),
        .out_row    (out_row),
        .out_col    (out_col),
        .edge_value (edge_value),
        .frame_done (frame_done)
    );

endmodule
`default_nettype wire
